### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion shorthands, with and without a reset guard.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked assertion, also checked while reset is active
`define ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

// clocked assertion, off while reset is active
`define ASSERT_CLK_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

`endif

### sv/ntc_pkg.sv
// ----------------------------------------------------------------------------
// ntc_pkg
// Shared types and constants of the thermistor converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ntc_pkg;

  localparam int CODE_W = 10;
  localparam int X_W    = 20;
  localparam int LN_W   = 28;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic signed [18:0] ZERO_C_CK = 19'sd27315;
  localparam logic signed [15:0] TEMP_MAX = 16'sh7FFF;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_OPEN   = 2'd1,
    ST_SHORT  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_PULL_UP    = 3'd0,
    REG_BETA       = 3'd1,
    REG_NOMINAL    = 3'd2,
    REG_SERIES     = 3'd3,
    REG_OPEN_TH    = 3'd4,
    REG_SHORT_TH   = 3'd5,
    REG_OPEN_TEMP  = 3'd6,
    REG_SHORT_TEMP = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic               pull_up;
    logic [13:0]        beta;
    logic [19:0]        nominal;
    logic [19:0]        series;
    logic [9:0]         open_th;
    logic [9:0]         short_th;
    logic signed [15:0] open_temp;
    logic signed [15:0] short_temp;
  } cfg_t;

  typedef struct packed {
    logic               fault;
    status_t            status;
    logic signed [15:0] temp;
    logic [X_W-1:0]     num_f;
    logic [X_W-1:0]     den_f;
  } q_item_t;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_SQ   = 4'b0010,
    L_MUL  = 4'b0100,
    L_SUM  = 4'b1000
  } log_state_t;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_LOG  = 8'b0000_0010,
    S_MUL  = 8'b0000_0100,
    S_DEN  = 8'b0000_1000,
    S_SET  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_FIN  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } back_state_t;

endpackage

### sv/ntc_thermistor_to_temperature.sv
// ----------------------------------------------------------------------------
// ntc_thermistor_to_temperature
// Converts thermistor divider ADC codes to temperature in 0.01 degC.
// ----------------------------------------------------------------------------
// Input channel: in_adc_code is taken when in_push is high and in_full low.
// The item is classified at once and written to a 4-deep queue.
// Result channel: out_sensor_status / out_temp_centi hold the oldest result
// while out_empty is low; out_pop takes it. A stalled receiver fills the
// result register, holds one finished item in the back end, then fills the
// queue, and then raises in_full.
// Configuration: cfg_we writes cfg_wdata to register cfg_index.
// Open or short items skip the arithmetic; a saturated denominator ends at
// the divider set-up; normal items pass the 28 squaring steps of the four
// parallel log units and the 17-step restoring divider.
// The back end serves one item at a time and takes the next from the queue
// only once the last has gone to the result register.
// Reset (rst_n low, synchronous) empties queue and result register and
// loads the configuration registers with their defaults.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ntc_thermistor_to_temperature import ntc_pkg::*; #(
  parameter int ADC_BITS            = 10,
  parameter int NOMINAL_CENTIKELVIN = 29815
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  logic [9:0]         in_adc_code,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [1:0]         out_sensor_status,
  output logic signed [15:0] out_temp_centi,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_wdata
);

  cfg_t    cfg_r;
  q_item_t f_item, q_item;
  logic    q_empty, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pull_up    <= 1'b0;
      cfg_r.beta       <= 14'd3950;
      cfg_r.nominal    <= 20'd10000;
      cfg_r.series     <= 20'd10000;
      cfg_r.open_th    <= 10'd1000;
      cfg_r.short_th   <= 10'd20;
      cfg_r.open_temp  <= -16'sd5500;
      cfg_r.short_temp <= 16'sd15000;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_PULL_UP:    cfg_r.pull_up    <= cfg_wdata[0];
        REG_BETA:       cfg_r.beta       <= cfg_wdata[13:0];
        REG_NOMINAL:    cfg_r.nominal    <= cfg_wdata;
        REG_SERIES:     cfg_r.series     <= cfg_wdata;
        REG_OPEN_TH:    cfg_r.open_th    <= cfg_wdata[9:0];
        REG_SHORT_TH:   cfg_r.short_th   <= cfg_wdata[9:0];
        REG_OPEN_TEMP:  cfg_r.open_temp  <= cfg_wdata[15:0];
        REG_SHORT_TEMP: cfg_r.short_temp <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  ntc_front #(.ADC_BITS(ADC_BITS)) u_front (
    .cfg  (cfg_r),
    .code (in_adc_code),
    .item (f_item)
  );

  ntc_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .wdata (f_item),
    .full  (in_full),
    .pop   (q_pop),
    .rdata (q_item),
    .empty (q_empty)
  );

  ntc_back #(.NOMINAL_CENTIKELVIN(NOMINAL_CENTIKELVIN)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .q_empty    (q_empty),
    .q_item     (q_item),
    .q_pop      (q_pop),
    .out_pop    (out_pop),
    .out_empty  (out_empty),
    .out_status (out_sensor_status),
    .out_temp   (out_temp_centi)
  );

endmodule

### sv/ntc_front.sv
// ----------------------------------------------------------------------------
// ntc_front
// Classifies an incoming code as normal, open or short and forms the
// divider factors for the back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ntc_front import ntc_pkg::*; #(
  parameter int ADC_BITS = 10
) (
  input  cfg_t              cfg,
  input  logic [CODE_W-1:0] code,
  output q_item_t           item
);

  localparam int CW = (ADC_BITS > CODE_W) ? ADC_BITS : CODE_W;

  logic [ADC_BITS-1:0] c;
  logic [ADC_BITS:0]   full_m;
  logic [CW-1:0]       cx, open_x, short_x;
  logic                is_open, is_short;

  always_comb begin
    c       = ADC_BITS'(code);
    full_m  = {1'b1, {ADC_BITS{1'b0}}} - {1'b0, c};
    cx      = CW'(c);
    open_x  = CW'(cfg.open_th);
    short_x = CW'(cfg.short_th);
    if (cfg.pull_up) begin
      is_open  = cx <= open_x;
      is_short = cx >= short_x;
    end else begin
      is_open  = cx >= open_x;
      is_short = cx <= short_x;
    end
    item.fault  = is_open || is_short || (c == '0);
    item.status = !item.fault ? ST_NORMAL : (is_open ? ST_OPEN : ST_SHORT);
    item.temp   = is_open ? cfg.open_temp : cfg.short_temp;
    if (cfg.pull_up) begin
      item.num_f = X_W'(full_m[ADC_BITS-1:0]);
      item.den_f = X_W'(c);
    end else begin
      item.num_f = X_W'(c);
      item.den_f = X_W'(full_m[ADC_BITS-1:0]);
    end
  end

endmodule

### sv/ntc_queue.sv
// ----------------------------------------------------------------------------
// ntc_queue
// Short item queue between the classifier and the arithmetic back end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ntc_queue import ntc_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  q_item_t wdata,
  output logic    full,
  input  logic    pop,
  output q_item_t rdata,
  output logic    empty
);

  q_item_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wp_r, rp_r;
  logic [QPTR_W:0]     cnt_r;
  logic                do_push, do_pop;

  assign full    = cnt_r == (QPTR_W+1)'(QDEPTH);
  assign empty   = cnt_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end

endmodule

### sv/ntc_log.sv
// ----------------------------------------------------------------------------
// ntc_log
// Iterative natural logarithm in Q24: leading one, 28 squaring steps for
// the log2 fraction, then scaling by ln2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ntc_log import ntc_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [X_W-1:0]  x,
  output logic            done,
  output logic [LN_W-1:0] ln
);

  log_state_t  state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [4:0]  k_r, k_nxt;
  logic [30:0] y_r, y_nxt;
  logic [27:0] frac_r, frac_nxt;
  logic [59:0] p1_r, p1_nxt;
  logic [36:0] p2_r, p2_nxt;
  logic [LN_W-1:0] ln_r, ln_nxt;
  logic        done_r, done_nxt;

  logic [X_W-1:0] xs;
  logic [4:0]     k;
  logic [61:0]    sq;
  logic [31:0]    t;
  logic [65:0]    acc;

  assign done = done_r;
  assign ln   = ln_r;

  always_comb begin
    xs = (x == '0) ? X_W'(1) : x;
    k  = '0;
    for (int i = 0; i < X_W; i++) begin
      if (xs[i]) k = 5'(i);
    end
    sq  = 62'(y_r) * 62'(y_r);
    t   = sq[61:30];
    acc = 66'({p2_r, 28'd0}) + 66'(p1_r) + (66'(1) << 35);
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    k_nxt     = k_r;
    y_nxt     = y_r;
    frac_nxt  = frac_r;
    p1_nxt    = p1_r;
    p2_nxt    = p2_r;
    ln_nxt    = ln_r;
    done_nxt  = 1'b0;
    unique case (state_r)
      L_IDLE: begin
        if (start) begin
          k_nxt     = k;
          y_nxt     = 31'({11'd0, xs} << (5'd30 - k));
          frac_nxt  = '0;
          cnt_nxt   = 5'd27;
          state_nxt = L_SQ;
        end
      end
      L_SQ: begin
        if (t[31]) y_nxt = t[31:1];
        else       y_nxt = t[30:0];
        frac_nxt = {frac_r[26:0], t[31]};
        cnt_nxt  = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = L_MUL;
      end
      L_MUL: begin
        p1_nxt    = 60'(frac_r) * 60'(LN2_Q32);
        p2_nxt    = 37'(k_r) * 37'(LN2_Q32);
        state_nxt = L_SUM;
      end
      L_SUM: begin
        ln_nxt    = acc[63:36];
        done_nxt  = 1'b1;
        state_nxt = L_IDLE;
      end
      default: state_nxt = L_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= L_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    y_r    <= y_nxt;
    frac_r <= frac_nxt;
    p1_r   <= p1_nxt;
    p2_r   <= p2_nxt;
    ln_r   <= ln_nxt;
  end

endmodule

### sv/ntc_back.sv
// ----------------------------------------------------------------------------
// ntc_back
// Back end: four log units, beta equation terms, 17-step restoring divider
// and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ntc_back import ntc_pkg::*; #(
  parameter int NOMINAL_CENTIKELVIN = 29815
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               q_empty,
  input  q_item_t            q_item,
  output logic               q_pop,
  input  logic               out_pop,
  output logic               out_empty,
  output logic [1:0]         out_status,
  output logic signed [15:0] out_temp
);

  localparam logic [15:0]        NOM16 = 16'(NOMINAL_CENTIKELVIN);
  localparam logic signed [16:0] NOM_S = 17'(NOMINAL_CENTIKELVIN);

  back_state_t        state_r, state_nxt;
  logic               out_vld_r, out_vld_nxt;
  logic [1:0]         out_stat_r, out_stat_nxt;
  logic signed [15:0] out_temp_r, out_temp_nxt;
  logic [1:0]         res_stat_r, res_stat_nxt;
  logic signed [15:0] res_temp_r, res_temp_nxt;
  logic signed [31:0] l_r, l_nxt;
  logic [20:0]        bc_r, bc_nxt;
  logic [29:0]        nb_r, nb_nxt;
  logic signed [48:0] nl_r, nl_nxt;
  logic [36:0]        nb100_r, nb100_nxt;
  logic signed [49:0] den_r, den_nxt;
  logic [63:0]        rem_r, rem_nxt;
  logic [65:0]        d_r, d_nxt;
  logic [16:0]        q_r, q_nxt;
  logic [4:0]         cnt_r, cnt_nxt;

  logic               log_start;
  logic [X_W-1:0]     lx [4];
  logic [3:0]         ldone;
  logic [LN_W-1:0]    lv [4];
  logic [63:0]        rem_init;
  logic               ge;
  logic signed [18:0] diff;

  always_comb begin
    lx[0] = (cfg.series == '0) ? X_W'(1) : cfg.series;
    lx[1] = q_item.num_f;
    lx[2] = (cfg.nominal == '0) ? X_W'(1) : cfg.nominal;
    lx[3] = q_item.den_f;
  end

  for (genvar g = 0; g < 4; g++) begin : g_log
    ntc_log u_log (
      .clk   (clk),
      .rst_n (rst_n),
      .start (log_start),
      .x     (lx[g]),
      .done  (ldone[g]),
      .ln    (lv[g])
    );
  end

  assign out_empty  = !out_vld_r;
  assign out_status = out_stat_r;
  assign out_temp   = out_temp_r;

  always_comb begin
    rem_init = 64'({nb100_r, 24'd0}) + 64'(den_r[49:1]);
    ge       = {2'b00, rem_r} >= d_r;
    diff     = $signed({2'b00, q_r}) - ZERO_C_CK;
  end

  always_comb begin
    state_nxt    = state_r;
    out_vld_nxt  = out_vld_r && !out_pop;
    out_stat_nxt = out_stat_r;
    out_temp_nxt = out_temp_r;
    res_stat_nxt = res_stat_r;
    res_temp_nxt = res_temp_r;
    l_nxt        = l_r;
    bc_nxt       = bc_r;
    nb_nxt       = nb_r;
    nl_nxt       = nl_r;
    nb100_nxt    = nb100_r;
    den_nxt      = den_r;
    rem_nxt      = rem_r;
    d_nxt        = d_r;
    q_nxt        = q_r;
    cnt_nxt      = cnt_r;
    q_pop        = 1'b0;
    log_start    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop        = 1'b1;
          res_stat_nxt = q_item.status;
          res_temp_nxt = q_item.temp;
          if (q_item.fault) begin
            state_nxt = S_DONE;
          end else begin
            log_start = 1'b1;
            state_nxt = S_LOG;
          end
        end
      end
      S_LOG: begin
        if (&ldone) begin
          l_nxt = $signed({4'd0, lv[0]}) + $signed({4'd0, lv[1]})
                - $signed({4'd0, lv[2]}) - $signed({4'd0, lv[3]});
          bc_nxt    = 21'(cfg.beta) * 21'd100;
          nb_nxt    = 30'(NOM16) * 30'(cfg.beta);
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        nl_nxt    = 49'(NOM_S) * 49'(l_r);
        nb100_nxt = 37'(nb_r) * 37'd100;
        state_nxt = S_DEN;
      end
      S_DEN: begin
        den_nxt   = $signed({5'd0, bc_r, 24'd0}) + {nl_r[48], nl_r};
        state_nxt = S_SET;
      end
      S_SET: begin
        rem_nxt = rem_init;
        d_nxt   = 66'({den_r[48:0], 16'd0});
        q_nxt   = '0;
        cnt_nxt = 5'd16;
        if (den_r[49] || den_r == '0 ||
            67'(rem_init) >= 67'({den_r[48:0], 17'd0})) begin
          res_temp_nxt = TEMP_MAX;
          state_nxt    = S_DONE;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (ge) rem_nxt = rem_r - d_r[63:0];
        d_nxt   = d_r >> 1;
        q_nxt   = {q_r[15:0], ge};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) state_nxt = S_FIN;
      end
      S_FIN: begin
        res_temp_nxt = (diff > 19'sd32767) ? TEMP_MAX : diff[15:0];
        state_nxt    = S_DONE;
      end
      S_DONE: begin
        if (!out_vld_r || out_pop) begin
          out_vld_nxt  = 1'b1;
          out_stat_nxt = res_stat_r;
          out_temp_nxt = res_temp_r;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_stat_r <= out_stat_nxt;
    out_temp_r <= out_temp_nxt;
    res_stat_r <= res_stat_nxt;
    res_temp_r <= res_temp_nxt;
    l_r        <= l_nxt;
    bc_r       <= bc_nxt;
    nb_r       <= nb_nxt;
    nl_r       <= nl_nxt;
    nb100_r    <= nb100_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    d_r        <= d_nxt;
    q_r        <= q_nxt;
    cnt_r      <= cnt_nxt;
  end

endmodule

### sv/ntc_checker.sv
// ----------------------------------------------------------------------------
// ntc_checker
// Port-level checks of the thermistor converter, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ntc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_pop,
  input logic [1:0]         out_sensor_status,
  input logic signed [15:0] out_temp_centi
);

  logic out_held;

  assign out_held = !out_empty && !out_pop;

  `ASSERT_CLK(a_rst_empty, clk, !rst_n |=> out_empty)
  `ASSERT_CLK(a_rst_not_full, clk, !rst_n |=> !in_full)
  `ASSERT_CLK_RST(a_status_code, clk, rst_n, !out_empty |-> out_sensor_status != 2'd3)
  `ASSERT_CLK_RST(a_hold_vld, clk, rst_n, out_held |=> !out_empty)
  `ASSERT_CLK_RST(a_hold_data, clk, rst_n, out_held |=> $stable({out_sensor_status, out_temp_centi}))

endmodule

bind ntc_thermistor_to_temperature ntc_checker u_ntc_checker (.*);

### test/tb_ntc_thermistor_to_temperature.sv
// ----------------------------------------------------------------------------
// tb_ntc_thermistor_to_temperature
// Self-checking bench for the thermistor-code to temperature converter.
// Walks a table of directed items and register writes (faults, wiring, zero
// resistors, zero beta, saturation), then random phases under random
// settings. Each result is checked against its row's value or a fixed-point
// beta-equation predictor, with random input bursts and receiver stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_ntc_thermistor_to_temperature;
  import ntc_pkg::*;

  localparam int IDLE_LIMIT   = 5000;
  localparam int NOM_CK       = 29815;
  localparam int RAND_PHASES  = 10;
  localparam int PHASE_ITEMS  = 150;

  typedef struct {
    status_t            st;
    logic signed [15:0] temp;
  } reading_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    reg_idx_t           idx;
    logic [19:0]        val;
    logic               typed;
    status_t            st;
    logic signed [15:0] temp;
  } row_t;

  logic               clk;
  logic               rst_n;
  logic               in_push;
  logic               in_full;
  logic [9:0]         in_adc_code;
  logic               out_empty;
  logic               out_pop;
  logic [1:0]         out_sensor_status;
  logic signed [15:0] out_temp_centi;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [19:0]        cfg_wdata;

  logic               sh_pull_up;
  logic [13:0]        sh_beta;
  logic [19:0]        sh_nominal;
  logic [19:0]        sh_series;
  logic [9:0]         sh_open_th;
  logic [9:0]         sh_short_th;
  logic signed [15:0] sh_open_temp;
  logic signed [15:0] sh_short_temp;

  reading_t pending_readings[$];
  int       err_cnt;
  int       items_sent;
  int       readings_seen;
  int       faults_seen;
  int       idle_cycles;
  bit       hold_req;
  int       pop_mode;

  ntc_thermistor_to_temperature uut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full), .in_adc_code(in_adc_code),
    .out_empty(out_empty), .out_pop(out_pop),
    .out_sensor_status(out_sensor_status), .out_temp_centi(out_temp_centi),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // natural log in Q24: log2 by leading one and squaring, times ln2
  function automatic longint ln_q24(logic [31:0] x);
    int        k;
    bit [63:0] y;
    bit [63:0] l2;
    k = 0;
    if (x == 0) x = 1;
    while (k < 31 && (x >> (k + 1)) != 0) k++;
    y = (k <= 30) ? (64'(x) << (30 - k)) : (64'(x) >> (k - 30));
    l2 = 64'(k) << 28;
    for (int i = 27; i >= 0; i--) begin
      y = (y * y) >> 30;
      if (y >= (64'd1 << 31)) begin
        y = y >> 1;
        l2[i] = 1'b1;
      end
    end
    return longint'((l2 * 64'd2977044472 + (64'd1 << 35)) >> 36);
  endfunction

  function automatic reading_t temp_from_code(logic [9:0] code);
    reading_t  r;
    bit        is_open;
    bit        is_short;
    logic [31:0] rs, r0, nf, df;
    longint    l, den, num, res;
    if (sh_pull_up) begin
      is_open  = code <= sh_open_th;
      is_short = code >= sh_short_th;
    end else begin
      is_open  = code >= sh_open_th;
      is_short = code <= sh_short_th;
    end
    if (is_open || is_short || code == 0) begin
      r.st   = is_open ? ST_OPEN : ST_SHORT;
      r.temp = is_open ? sh_open_temp : sh_short_temp;
      return r;
    end
    rs = (sh_series == 0) ? 1 : sh_series;
    r0 = (sh_nominal == 0) ? 1 : sh_nominal;
    nf = sh_pull_up ? 1024 - code : code;
    df = sh_pull_up ? code : 1024 - code;
    l = ln_q24(rs) + ln_q24(nf) - ln_q24(r0) - ln_q24(df);
    den = longint'(sh_beta) * 100 * (64'sd1 << 24) + longint'(NOM_CK) * l;
    if (den <= 0) begin
      res = 32767;
    end else begin
      num = longint'(NOM_CK) * longint'(sh_beta) * 100 * (64'sd1 << 24);
      res = (num + den / 2) / den - 27315;
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
    end
    r.st = ST_NORMAL;
    r.temp = res[15:0];
    return r;
  endfunction

  task automatic write_reg(reg_idx_t idx, logic [19:0] v);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    case (idx)
      REG_PULL_UP:    sh_pull_up    = v[0];
      REG_BETA:       sh_beta       = v[13:0];
      REG_NOMINAL:    sh_nominal    = v;
      REG_SERIES:     sh_series     = v;
      REG_OPEN_TH:    sh_open_th    = v[9:0];
      REG_SHORT_TH:   sh_short_th   = v[9:0];
      REG_OPEN_TEMP:  sh_open_temp  = v[15:0];
      REG_SHORT_TEMP: sh_short_temp = v[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic drain();
    in_push <= 1'b0;
    cfg_we  <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_item(logic [9:0] code, bit typed, reading_t want);
    in_push     <= 1'b1;
    in_adc_code <= code;
    do @(posedge clk); while (in_full);
    pending_readings.push_back(typed ? want : temp_from_code(code));
    items_sent++;
  endtask

  task automatic random_settings();
    bit          pu;
    logic [19:0] v;
    pu = 1'($urandom_range(0, 1));
    write_reg(REG_PULL_UP, 20'(pu));
    case ($urandom_range(0, 5))
      0: v = 20'd1000;
      1: v = 20'd10000;
      default: v = 20'($urandom_range(1000, 10000));
    endcase
    write_reg(REG_BETA, v);
    v = ($urandom_range(0, 7) == 0) ? 20'd1000000 : 20'($urandom_range(100, 1000000));
    write_reg(REG_NOMINAL, v);
    v = ($urandom_range(0, 7) == 0) ? 20'd100 : 20'($urandom_range(100, 1000000));
    write_reg(REG_SERIES, v);
    if (pu) begin
      write_reg(REG_OPEN_TH, 20'($urandom_range(0, 100)));
      write_reg(REG_SHORT_TH, 20'($urandom_range(900, 1023)));
    end else begin
      write_reg(REG_OPEN_TH, 20'($urandom_range(900, 1023)));
      write_reg(REG_SHORT_TH, 20'($urandom_range(0, 100)));
    end
    write_reg(REG_OPEN_TEMP, 20'($urandom_range(0, 65535)));
    write_reg(REG_SHORT_TEMP, 20'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // receiver: stall pattern switches between four random modes; long hold on request
  initial begin
    int cyc;
    cyc = 0;
    out_pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_pop <= 1'b0;
        repeat (400) @(posedge clk);
      end
      cyc++;
      if (cyc % 200 == 0) pop_mode = $urandom_range(0, 3);
      case (pop_mode)
        0: out_pop <= 1'b1;
        1: out_pop <= 1'($urandom_range(0, 1));
        2: out_pop <= (cyc % 4 == 0);
        default: out_pop <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    reading_t want;
    if (rst_n && out_pop && !out_empty) begin
      readings_seen++;
      if (out_sensor_status != ST_NORMAL) faults_seen++;
      if (pending_readings.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("ERROR: unexpected reading status=%0d temp=%0d",
                   out_sensor_status, out_temp_centi);
      end else begin
        want = pending_readings.pop_front();
        if (out_sensor_status != want.st || out_temp_centi != want.temp) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("ERROR: reading exp status=%0d temp=%0d got status=%0d temp=%0d",
                     want.st, want.temp, out_sensor_status, out_temp_centi);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic row_t cfg_row(reg_idx_t idx, int v);
    row_t r;
    r.kind = ROW_CFG; r.idx = idx; r.val = 20'(v); r.typed = 1'b0;
    r.st = ST_NORMAL; r.temp = '0;
    return r;
  endfunction

  function automatic row_t item_row(int code, int typed, status_t st, int temp);
    row_t r;
    r.kind = ROW_ITEM; r.idx = REG_PULL_UP; r.val = 20'(code); r.typed = (typed != 0);
    r.st = st; r.temp = 16'(temp);
    return r;
  endfunction

  initial begin
    row_t     rows[$];
    reading_t want;
    bit       in_cfg;
    int       burst;
    rst_n = 1'b0;
    in_push = 1'b0;
    in_adc_code = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    err_cnt = 0; items_sent = 0; readings_seen = 0; faults_seen = 0;
    idle_cycles = 0; hold_req = 1'b0; pop_mode = 0;
    sh_pull_up = 1'b0; sh_beta = 14'd3950; sh_nominal = 20'd10000; sh_series = 20'd10000;
    sh_open_th = 10'd1000; sh_short_th = 10'd20;
    sh_open_temp = -16'sd5500; sh_short_temp = 16'sd15000;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: faults at both ends, thresholds, balanced divider gives 25.00
    rows.push_back(item_row(0, 1, ST_SHORT, 15000));
    rows.push_back(item_row(1023, 1, ST_OPEN, -5500));
    rows.push_back(item_row(1000, 1, ST_OPEN, -5500));
    rows.push_back(item_row(999, 0, ST_NORMAL, 0));
    rows.push_back(item_row(20, 1, ST_SHORT, 15000));
    rows.push_back(item_row(21, 0, ST_NORMAL, 0));
    rows.push_back(item_row(512, 1, ST_NORMAL, 2500));
    // pull-up wiring mirrors the tests
    rows.push_back(cfg_row(REG_PULL_UP, 1));
    rows.push_back(cfg_row(REG_OPEN_TH, 10));
    rows.push_back(cfg_row(REG_SHORT_TH, 1000));
    rows.push_back(item_row(10, 1, ST_OPEN, -5500));
    rows.push_back(item_row(1000, 1, ST_SHORT, 15000));
    rows.push_back(item_row(11, 0, ST_NORMAL, 0));
    rows.push_back(item_row(999, 0, ST_NORMAL, 0));
    rows.push_back(item_row(512, 1, ST_NORMAL, 2500));
    // both faults met: open wins
    rows.push_back(cfg_row(REG_PULL_UP, 0));
    rows.push_back(cfg_row(REG_SHORT_TH, 500));
    rows.push_back(item_row(300, 1, ST_OPEN, -5500));
    // zero beta gives 0 K; zero resistors read as 1 ohm; negative denominator
    rows.push_back(cfg_row(REG_OPEN_TH, 1023));
    rows.push_back(cfg_row(REG_SHORT_TH, 0));
    rows.push_back(cfg_row(REG_BETA, 0));
    rows.push_back(cfg_row(REG_SERIES, 1000000));
    rows.push_back(cfg_row(REG_NOMINAL, 0));
    rows.push_back(item_row(700, 1, ST_NORMAL, -27315));
    rows.push_back(cfg_row(REG_SERIES, 0));
    rows.push_back(cfg_row(REG_NOMINAL, 1000000));
    rows.push_back(item_row(5, 1, ST_NORMAL, 32767));
    // beta extreme, temperature register extremes
    rows.push_back(cfg_row(REG_BETA, 10000));
    rows.push_back(cfg_row(REG_SERIES, 100));
    rows.push_back(item_row(1, 0, ST_NORMAL, 0));
    rows.push_back(item_row(1022, 0, ST_NORMAL, 0));
    rows.push_back(cfg_row(REG_OPEN_TEMP, 'h08000));
    rows.push_back(cfg_row(REG_SHORT_TEMP, 'h07FFF));
    rows.push_back(item_row(0, 1, ST_SHORT, 32767));
    rows.push_back(item_row(1023, 1, ST_OPEN, -32768));

    in_cfg = 1'b0;
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        if (!in_cfg) drain();
        in_cfg = 1'b1;
        write_reg(rows[i].idx, rows[i].val);
      end else begin
        if (in_cfg) begin
          cfg_we <= 1'b0;
          @(posedge clk);
        end
        in_cfg = 1'b0;
        want.st = rows[i].st;
        want.temp = rows[i].temp;
        send_item(rows[i].val[9:0], rows[i].typed, want);
      end
    end
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_settings();
      if (ph == 1) hold_req = 1'b1;
      burst = $urandom_range(1, 20);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        send_item(10'($urandom_range(0, 1023)), 1'b0, want);
        burst--;
        if (burst == 0) begin
          burst = $urandom_range(1, 20);
          if ($urandom_range(0, 2) != 0) begin
            in_push <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
          end
        end
      end
      drain();
    end

    repeat (80) @(posedge clk);
    $display("Covered %0d items, %0d readings (%0d faults) over %0d random settings",
             items_sent, readings_seen, faults_seen, RAND_PHASES);
    $display("Bursty input, varied output stalls, one long hold-off; %0d mismatches",
             err_cnt);
    if (err_cnt == 0 && pending_readings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
